FILE: hdl/assert_macros.svh
// Assertion helpers for the checker file scu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication checked on every rising edge outside reset.
`define SCU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scu assertion failed");

// A stalled beat must come back unchanged on the next edge.
`define SCU_ASSERT_HOLD(lbl, clk, rst_n, stall, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) stall |=> $stable(sig)) \
    else $error("scu stalled beat changed");

`endif

FILE: hdl/scu_pkg.sv
`timescale 1ns / 1ps
package scu_pkg;

  localparam int FRAC_BITS = 8;

  // |raw - low_count| is 16 bits, |high_unit - low_unit| is 7 bits
  localparam int PROD_W  = 23;
  localparam int QUO_W   = PROD_W + FRAC_BITS;
  localparam int VAL_W   = QUO_W + 2;
  // input stage, product stage, one stage per quotient bit, final add
  localparam int DEPTH   = QUO_W + 3;

  localparam int HUM_TOP_FULL = 100 << FRAC_BITS;
  localparam logic [14:0] HUM_TOP = 15'((HUM_TOP_FULL > 32767) ? 32767 : HUM_TOP_FULL);

  localparam logic signed [VAL_W-1:0] TEMP_MAX_V = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] TEMP_MIN_V = VAL_W'(-32768);
  localparam logic signed [VAL_W-1:0] HUM_TOP_V  = VAL_W'(HUM_TOP);

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TEMP_LOW_DEG    = 3'd0;
  localparam logic [2:0] REG_TEMP_HIGH_DEG   = 3'd1;
  localparam logic [2:0] REG_TEMP_LOW_COUNT  = 3'd2;
  localparam logic [2:0] REG_TEMP_HIGH_COUNT = 3'd3;
  localparam logic [2:0] REG_HUMID_LOW_PCT   = 3'd4;
  localparam logic [2:0] REG_HUMID_HIGH_PCT  = 3'd5;
  localparam logic [2:0] REG_HUMID_LOW_COUNT = 3'd6;
  localparam logic [2:0] REG_HUMID_HIGH_COUNT = 3'd7;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    zero_span;
  } lane_res_t;

endpackage

FILE: hdl/scu_lane.sv
`timescale 1ns / 1ps
module scu_lane import scu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic signed [15:0] raw_i,
  input  logic signed [15:0] lo_cnt_i,
  input  logic signed [15:0] hi_cnt_i,
  input  logic [6:0]        lo_unit_i,
  input  logic [6:0]        hi_unit_i,
  output lane_res_t         res_o
);

  logic signed [16:0] diff;
  logic signed [16:0] span;
  logic signed [7:0]  du;

  logic [15:0] a_diff_mag_q;
  logic [6:0]  a_du_mag_q;
  logic [15:0] a_span_mag_q;
  logic        a_neg_q;
  logic        a_zero_q;
  logic [6:0]  a_lo_q;

  logic [15:0]      rem_q  [QUO_W+1];
  logic [QUO_W-1:0] w_q    [QUO_W+1];
  logic [15:0]      div_q  [QUO_W+1];
  logic             neg_q  [QUO_W+1];
  logic             zero_q [QUO_W+1];
  logic [6:0]       lo_q   [QUO_W+1];

  logic [PROD_W-1:0]       prod;
  logic signed [VAL_W-1:0] q_ext;
  logic signed [VAL_W-1:0] q_signed;
  logic signed [VAL_W-1:0] lo_ext;
  lane_res_t               res_d;
  lane_res_t               res_q;

  assign diff = 17'(raw_i) - 17'(lo_cnt_i);
  assign span = 17'(hi_cnt_i) - 17'(lo_cnt_i);
  assign du   = $signed({1'b0, hi_unit_i}) - $signed({1'b0, lo_unit_i});

  // sign and magnitude, so the divider only sees unsigned values
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_diff_mag_q <= diff[16] ? 16'(-diff) : diff[15:0];
      a_du_mag_q   <= du[7] ? 7'(-du) : du[6:0];
      a_span_mag_q <= span[16] ? 16'(-span) : span[15:0];
      a_neg_q      <= diff[16] ^ du[7] ^ span[16];
      a_zero_q     <= (span == 17'sd0);
      a_lo_q       <= lo_unit_i;
    end
  end

  assign prod = PROD_W'(a_diff_mag_q) * PROD_W'(a_du_mag_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      w_q[0]    <= QUO_W'({prod, {FRAC_BITS{1'b0}}});
      div_q[0]  <= a_span_mag_q;
      neg_q[0]  <= a_neg_q;
      zero_q[0] <= a_zero_q;
      lo_q[0]   <= a_lo_q;
    end
  end

  // restoring division, one quotient bit per stage, dividend MSB first
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [16:0] trial;
    logic [16:0] rem_sub;
    logic        take;

    assign trial   = {rem_q[k], w_q[k][QUO_W-1]};
    assign take    = trial >= {1'b0, div_q[k]};
    assign rem_sub = trial - {1'b0, div_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? rem_sub[15:0] : trial[15:0];
        w_q[k+1]    <= {w_q[k][QUO_W-2:0], take};
        div_q[k+1]  <= div_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        lo_q[k+1]   <= lo_q[k];
      end
    end
  end

  assign q_ext    = $signed({2'b00, w_q[QUO_W]});
  assign q_signed = neg_q[QUO_W] ? -q_ext : q_ext;
  assign lo_ext   = $signed(VAL_W'({lo_q[QUO_W], {FRAC_BITS{1'b0}}}));

  always_comb begin
    res_d.val       = q_signed + lo_ext;
    res_d.zero_span = zero_q[QUO_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: hdl/scu_merge.sv
`timescale 1ns / 1ps
module scu_merge import scu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      last_valid_i,
  input  lane_res_t temp_i,
  input  lane_res_t humid_i,
  input  logic      m_axis_tready,
  output logic      en_o,
  output logic      m_axis_tvalid,
  output logic [31:0] m_axis_tdata,  // [15:0] temperature_fixed, [30:16] humidity_fixed
  output logic [0:0]  m_axis_tuser   // [0] span_error
);

  logic        out_valid_q;
  logic        out_valid_d;
  logic [15:0] temp_q;
  logic [15:0] temp_d;
  logic [14:0] humid_q;
  logic [14:0] humid_d;
  logic        err_q;
  logic        err_d;
  logic        slot_free;
  logic        load;

  assign slot_free = !out_valid_q || m_axis_tready;
  // pipeline keeps moving while its last stage is empty or the output slot is free
  assign en_o      = !last_valid_i || slot_free;
  assign load      = last_valid_i && slot_free;

  always_comb begin
    err_d = temp_i.zero_span || humid_i.zero_span;

    if (temp_i.val > TEMP_MAX_V) begin
      temp_d = 16'h7fff;
    end else if (temp_i.val < TEMP_MIN_V) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = temp_i.val[15:0];
    end

    if (humid_i.val < 0) begin
      humid_d = '0;
    end else if (humid_i.val > HUM_TOP_V) begin
      humid_d = HUM_TOP;
    end else begin
      humid_d = humid_i.val[14:0];
    end

    if (err_d) begin
      temp_d  = '0;
      humid_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      temp_q  <= temp_d;
      humid_q <= humid_d;
      err_q   <= err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, humid_q, temp_q};
  assign m_axis_tuser  = err_q;

endmodule

FILE: hdl/two_point_sensor_calibration_unit.sv
`timescale 1ns / 1ps
// Two-point calibration of a temperature / humidity pair. Each beat carries
// one raw temperature count and one raw humidity count; both are mapped
// linearly between the low and high calibration points in the eight APB
// registers and come out in 1/256 units (FRAC_BITS = 8). Temperature
// saturates to 16 bits signed, humidity clamps to 0..100 %RH, and a zero
// count span on either channel sets tuser and zeroes both values. The two
// channels run in twin lanes, each a pipeline of FRAC_BITS + 26 stages built
// around a restoring divider that resolves one quotient bit per stage; one
// beat is taken every cycle unless a stalled output holds the pipeline. Registers
// are meant to be written while no beat is in flight.
module two_point_sensor_calibration_unit import scu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] temp_raw, [31:16] humid_raw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] temperature_fixed, [30:16] humidity_fixed
  output logic [0:0]  m_axis_tuser,   // [0] span_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]        t_lo_deg_q;
  logic [6:0]        t_hi_deg_q;
  logic signed [15:0] t_lo_cnt_q;
  logic signed [15:0] t_hi_cnt_q;
  logic [6:0]        h_lo_pct_q;
  logic [6:0]        h_hi_pct_q;
  logic signed [15:0] h_lo_cnt_q;
  logic signed [15:0] h_hi_cnt_q;

  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             en;
  logic [DEPTH-1:0] valid_q;
  lane_res_t        temp_res;
  lane_res_t        humid_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_lo_deg_q <= '0;
      t_hi_deg_q <= '0;
      t_lo_cnt_q <= '0;
      t_hi_cnt_q <= '0;
      h_lo_pct_q <= '0;
      h_hi_pct_q <= '0;
      h_lo_cnt_q <= '0;
      h_hi_cnt_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEMP_LOW_DEG:     t_lo_deg_q <= pwdata[6:0];
        REG_TEMP_HIGH_DEG:    t_hi_deg_q <= pwdata[6:0];
        REG_TEMP_LOW_COUNT:   t_lo_cnt_q <= pwdata[15:0];
        REG_TEMP_HIGH_COUNT:  t_hi_cnt_q <= pwdata[15:0];
        REG_HUMID_LOW_PCT:    h_lo_pct_q <= pwdata[6:0];
        REG_HUMID_HIGH_PCT:   h_hi_pct_q <= pwdata[6:0];
        REG_HUMID_LOW_COUNT:  h_lo_cnt_q <= pwdata[15:0];
        REG_HUMID_HIGH_COUNT: h_hi_cnt_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEMP_LOW_DEG:     prdata = 32'(t_lo_deg_q);
      REG_TEMP_HIGH_DEG:    prdata = 32'(t_hi_deg_q);
      REG_TEMP_LOW_COUNT:   prdata = 32'(unsigned'(t_lo_cnt_q));
      REG_TEMP_HIGH_COUNT:  prdata = 32'(unsigned'(t_hi_cnt_q));
      REG_HUMID_LOW_PCT:    prdata = 32'(h_lo_pct_q);
      REG_HUMID_HIGH_PCT:   prdata = 32'(h_hi_pct_q);
      REG_HUMID_LOW_COUNT:  prdata = 32'(unsigned'(h_lo_cnt_q));
      REG_HUMID_HIGH_COUNT: prdata = 32'(unsigned'(h_hi_cnt_q));
    endcase
  end

  assign s_axis_tready = en;

  // one valid bit per lane stage; both lanes advance in lockstep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  scu_lane u_temp_lane (
    .clk_i     (clk_i),
    .en_i      (en),
    .raw_i     (s_axis_tdata[15:0]),
    .lo_cnt_i  (t_lo_cnt_q),
    .hi_cnt_i  (t_hi_cnt_q),
    .lo_unit_i (t_lo_deg_q),
    .hi_unit_i (t_hi_deg_q),
    .res_o     (temp_res)
  );

  scu_lane u_humid_lane (
    .clk_i     (clk_i),
    .en_i      (en),
    .raw_i     (s_axis_tdata[31:16]),
    .lo_cnt_i  (h_lo_cnt_q),
    .hi_cnt_i  (h_hi_cnt_q),
    .lo_unit_i (h_lo_pct_q),
    .hi_unit_i (h_hi_pct_q),
    .res_o     (humid_res)
  );

  scu_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .last_valid_i  (valid_q[DEPTH-1]),
    .temp_i        (temp_res),
    .humid_i       (humid_res),
    .m_axis_tready (m_axis_tready),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: hdl/scu_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scu_checker import scu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic        stall;
  logic        err_beat;
  logic        slot_open;
  logic [33:0] out_beat;
  logic [14:0] humid_val;

  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign err_beat  = m_axis_tvalid && m_axis_tuser[0];
  assign slot_open = !m_axis_tvalid || m_axis_tready;
  assign out_beat  = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
  assign humid_val = m_axis_tdata[30:16];

  `SCU_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, stall, out_beat)

  // a zero span result carries zero values
  `SCU_ASSERT(a_span_zero, clk_i, rst_ni, err_beat |-> (m_axis_tdata == 32'd0))

  // humidity never leaves the 0..100 % clamp
  `SCU_ASSERT(a_humid_clamp, clk_i, rst_ni, m_axis_tvalid |-> (humid_val <= HUM_TOP))

  // an empty or draining output slot never holds off the input
  `SCU_ASSERT(a_no_block, clk_i, rst_ni, slot_open |-> s_axis_tready)

endmodule

bind two_point_sensor_calibration_unit scu_checker u_scu_checker (.*);

FILE: tb/sv/tb_two_point_sensor_calibration_unit.sv
`timescale 1ns / 1ps
module tb_two_point_sensor_calibration_unit;
  import scu_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [14:0]        hum;
    logic               span_err;
  } cal_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] temp_raw, [31:16] humid_raw
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] temperature_fixed, [30:16] humidity_fixed
  logic [0:0]  m_axis_tuser;   // [0] span_error
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] cal_regs [8];
  cal_result_t expected_cal_q [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idle_on;

  two_point_sensor_calibration_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: exact integer interpolation, truncating toward zero
  // ---------------------------------------------------------------------------
  function automatic longint lin_map(longint raw, longint lo_cnt, longint hi_cnt,
                                     longint lo_u, longint hi_u);
    longint scale;
    scale = longint'(1) <<< FRAC_BITS;
    return (raw - lo_cnt) * (hi_u - lo_u) * scale / (hi_cnt - lo_cnt) + lo_u * scale;
  endfunction

  function automatic cal_result_t calibrate_pair(logic [15:0] t_raw, logic [15:0] h_raw);
    longint t_lo_cnt, t_hi_cnt, h_lo_cnt, h_hi_cnt;
    longint t, h, h_top;
    cal_result_t r;
    t_lo_cnt = longint'($signed(cal_regs[REG_TEMP_LOW_COUNT][15:0]));
    t_hi_cnt = longint'($signed(cal_regs[REG_TEMP_HIGH_COUNT][15:0]));
    h_lo_cnt = longint'($signed(cal_regs[REG_HUMID_LOW_COUNT][15:0]));
    h_hi_cnt = longint'($signed(cal_regs[REG_HUMID_HIGH_COUNT][15:0]));
    r = '0;
    if (t_hi_cnt == t_lo_cnt || h_hi_cnt == h_lo_cnt) begin
      r.span_err = 1'b1;
    end else begin
      t = lin_map(longint'($signed(t_raw)), t_lo_cnt, t_hi_cnt,
                  longint'(cal_regs[REG_TEMP_LOW_DEG][6:0]),
                  longint'(cal_regs[REG_TEMP_HIGH_DEG][6:0]));
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      h = lin_map(longint'($signed(h_raw)), h_lo_cnt, h_hi_cnt,
                  longint'(cal_regs[REG_HUMID_LOW_PCT][6:0]),
                  longint'(cal_regs[REG_HUMID_HIGH_PCT][6:0]));
      h_top = longint'(100) <<< FRAC_BITS;
      if (h < 0) h = 0;
      if (h > h_top) h = h_top;
      if (h > 32767) h = 32767;
      r.temp = t[15:0];
      r.hum  = h[14:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus drivers
  // ---------------------------------------------------------------------------
  task automatic send_reading(input logic [15:0] t_raw, input logic [15:0] h_raw);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h_raw, t_raw};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_cal_q.push_back(calibrate_pair(t_raw, h_raw));
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_cal_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cal_regs[idx] = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_channels(input int t_lo_deg, input int t_hi_deg,
                              input int t_lo_cnt, input int t_hi_cnt,
                              input int h_lo_pct, input int h_hi_pct,
                              input int h_lo_cnt, input int h_hi_cnt);
    cfg_write(REG_TEMP_LOW_DEG,     32'(t_lo_deg));
    cfg_write(REG_TEMP_HIGH_DEG,    32'(t_hi_deg));
    cfg_write(REG_TEMP_LOW_COUNT,   32'(t_lo_cnt));
    cfg_write(REG_TEMP_HIGH_COUNT,  32'(t_hi_cnt));
    cfg_write(REG_HUMID_LOW_PCT,    32'(h_lo_pct));
    cfg_write(REG_HUMID_HIGH_PCT,   32'(h_hi_pct));
    cfg_write(REG_HUMID_LOW_COUNT,  32'(h_lo_cnt));
    cfg_write(REG_HUMID_HIGH_COUNT, 32'(h_hi_cnt));
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] pick_count(logic [15:0] lo, logic [15:0] hi);
    int lo_i, hi_i, k, v;
    lo_i = int'($signed(lo));
    hi_i = int'($signed(hi));
    case ($urandom_range(0, 9)) inside
      [0:3]: v = int'($signed(16'($urandom)));
      [4:7]: begin
        // mostly inside the calibrated span, a little beyond on each side
        k = $urandom_range(0, 1200);
        v = lo_i + (hi_i - lo_i) * (k - 100) / 1000;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(0, 1) ? lo_i : hi_i;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [31:0] rand_unit();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[6:0] = 7'd0;
      1: v[6:0] = 7'd127;
      default: ;
    endcase
    return v;
  endfunction

  task automatic rand_span(output logic [31:0] lo_w, output logic [31:0] hi_w);
    logic [15:0] lo, hi;
    int lo_i;
    lo = 16'($urandom);
    case ($urandom_range(0, 11)) inside
      0: hi = lo;
      1: begin
        lo = 16'h8000;
        hi = 16'h7fff;
      end
      2: begin
        lo = 16'h7fff;
        hi = 16'h8000;
      end
      [3:6]: begin
        lo_i = $urandom_range(0, 40000) - 20000;
        lo   = lo_i[15:0];
        hi   = 16'(lo_i + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 8000));
      end
      default: hi = 16'($urandom);
    endcase
    lo_w = {16'($urandom), lo};
    hi_w = {16'($urandom), hi};
  endtask

  task automatic rand_calibration();
    logic [31:0] lo_w, hi_w;
    cfg_write(REG_TEMP_LOW_DEG,  rand_unit());
    cfg_write(REG_TEMP_HIGH_DEG, rand_unit());
    rand_span(lo_w, hi_w);
    cfg_write(REG_TEMP_LOW_COUNT,  lo_w);
    cfg_write(REG_TEMP_HIGH_COUNT, hi_w);
    cfg_write(REG_HUMID_LOW_PCT,  rand_unit());
    cfg_write(REG_HUMID_HIGH_PCT, rand_unit());
    rand_span(lo_w, hi_w);
    cfg_write(REG_HUMID_LOW_COUNT,  lo_w);
    cfg_write(REG_HUMID_HIGH_COUNT, hi_w);
  endtask

  task automatic send_random_readings(input int count);
    repeat (count) begin
      send_reading(pick_count(cal_regs[REG_TEMP_LOW_COUNT][15:0],
                              cal_regs[REG_TEMP_HIGH_COUNT][15:0]),
                   pick_count(cal_regs[REG_HUMID_LOW_COUNT][15:0],
                              cal_regs[REG_HUMID_HIGH_COUNT][15:0]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    // all registers zero: both spans are zero
    send_reading(16'h0000, 16'h0000);
    send_reading(16'h7fff, 16'h8000);
  endtask

  task automatic test_nominal();
    drain_pipeline();
    cfg_channels(0, 100, -4000, 12000, 20, 80, 1000, 9000);
    send_reading(16'(-4000), 16'd1000);
    send_reading(16'd12000, 16'd9000);
    send_reading(16'd4000, 16'd5000);
    send_reading(16'd0, 16'd0);
    send_reading(16'h7fff, 16'h7fff);
    send_reading(16'h8000, 16'h8000);
    send_reading(16'd1, 16'hffff);
    send_reading(16'hffff, 16'd8999);
  endtask

  task automatic test_saturation();
    drain_pipeline();
    cfg_channels(0, 127, 0, 1, 0, 127, 0, 1);
    send_reading(16'h7fff, 16'h7fff);
    send_reading(16'h8000, 16'h8000);
    send_reading(16'd1, 16'd1);
    send_reading(16'd0, 16'd0);
  endtask

  task automatic test_inverted_extremes();
    drain_pipeline();
    cfg_channels(127, 0, 32767, -32768, 127, 0, 32767, -32768);
    send_reading(16'h7fff, 16'h7fff);
    send_reading(16'h8000, 16'h8000);
    send_reading(16'h0000, 16'h5555);
    send_reading(16'haaaa, 16'hffff);
  endtask

  task automatic test_span_errors();
    drain_pipeline();
    // humidity span zero, temperature fine
    cfg_channels(10, 50, 100, 900, 30, 60, 777, 777);
    send_reading(16'd500, 16'd777);
    send_reading(16'h7fff, 16'h8000);
    drain_pipeline();
    // temperature span zero, humidity fine
    cfg_write(REG_HUMID_HIGH_COUNT, 32'd2000);
    cfg_write(REG_TEMP_HIGH_COUNT, 32'd100);
    send_reading(16'd100, 16'd1500);
    send_reading(16'h8000, 16'h7fff);
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    repeat (phases) begin
      drain_pipeline();
      rand_calibration();
      send_random_readings(per_phase);
    end
  endtask

  task automatic test_full_rate();
    drain_pipeline();
    idle_on = 1'b0;
    rand_calibration();
    send_random_readings(300);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts while idling is enabled
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    cal_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.temp     = m_axis_tdata[15:0];
      got.hum      = m_axis_tdata[30:16];
      got.span_err = m_axis_tuser[0];
      if (expected_cal_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: unexpected beat temp=%0d hum=%0d span_err=%0b",
                   got.temp, got.hum, got.span_err);
      end else begin
        want = expected_cal_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: exp temp=%0d hum=%0d err=%0b, got temp=%0d hum=%0d err=%0b",
                     want.temp, want.hum, want.span_err, got.temp, got.hum, got.span_err);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    idle_on       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (int i = 0; i < 8; i++) cal_regs[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  <= 1'b1;
    idle_on = 1'b1;

    test_reset_defaults();
    test_nominal();
    test_saturation();
    test_inverted_extremes();
    test_span_errors();
    test_random_phases(10, 150);
    test_full_rate();

    drain_pipeline();
    repeat (DEPTH + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
